// ===== hdl/tdas_pkg.sv =====
// Shared types and constants for the two-door airlock sequencer.
// Used by tdas_cfg, tdas_core and the top level; no dependencies.
package tdas_pkg;

    localparam int TIME_BITS = 32;
    localparam int ADDR_BITS = 5;
    localparam int PULSE_MS  = 10;

    typedef logic [TIME_BITS-1:0] stamp_t;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_FIRE_SEND    = 4'd1,
        PH_FIRE_HOLD    = 4'd2,
        PH_FIRE_EXIT    = 4'd3,
        PH_OPEN1_SEND   = 4'd4,
        PH_OPEN1_WAIT   = 4'd5,
        PH_WAIT_PERSON  = 4'd6,
        PH_CLOSE1_SEND  = 4'd7,
        PH_SWITCH_DELAY = 4'd8,
        PH_OPEN2_SEND   = 4'd9,
        PH_OPEN2_WAIT   = 4'd10,
        PH_HOLD2        = 4'd11,
        PH_CLOSE2_SEND  = 4'd12
    } phase_t;

    localparam logic [1:0] CMD_OPEN_FIRST  = 2'd0;
    localparam logic [1:0] CMD_OPEN_SECOND = 2'd1;
    localparam logic [1:0] CMD_CLOSE       = 2'd2;

    localparam logic DOOR_A = 1'b0;
    localparam logic DOOR_B = 1'b1;

    localparam logic [15:0] MASK_FIRST_OPEN  = 16'h0002;
    localparam logic [15:0] MASK_SECOND_OPEN = 16'h0001;

    localparam int LN_RED_A   = 0;
    localparam int LN_GREEN_A = 1;
    localparam int LN_STAT_A  = 2;
    localparam int LN_RED_B   = 3;
    localparam int LN_GREEN_B = 4;
    localparam int LN_STAT_B  = 5;
    localparam int LN_ENTER   = 6;
    localparam int LN_LEAVE   = 7;
    localparam int LN_PASS    = 8;

    localparam int OPT_SKIP_CONFIRM = 1;
    localparam int OPT_WAIT_EMPTY   = 2;
    localparam int OPT_MAX_HOLD     = 3;
    localparam int OPT_AUTO         = 4;
    localparam int OPT_TEST         = 5;
    localparam int OPT_FIRE_INVERT  = 6;

    localparam logic [2:0] REG_OPEN_CONFIRM = 3'd0;
    localparam logic [2:0] REG_PERSON_WAIT  = 3'd1;
    localparam logic [2:0] REG_SWITCH_DELAY = 3'd2;
    localparam logic [2:0] REG_CLOSE_DELAY  = 3'd3;
    localparam logic [2:0] REG_MAX_HOLD     = 3'd4;
    localparam logic [2:0] REG_OPTIONS      = 3'd5;

    typedef struct packed {
        logic [15:0] open_confirm_timeout;
        logic [15:0] person_wait_timeout;
        logic [15:0] switch_delay;
        logic [15:0] second_close_delay;
        logic [15:0] second_max_hold;
        logic [6:0]  option_flags;
    } cfg_t;

    typedef struct packed {
        logic        request_a;
        logic        request_b;
        logic        fire_raw;
        logic [15:0] door_a_status;
        logic [15:0] door_b_status;
        logic        people_valid;
        logic [7:0]  people_count;
        logic        bus_ready;
    } in_item_t;

    typedef struct packed {
        logic        command_valid;
        logic        command_door;
        logic [1:0]  command_code;
        logic [8:0]  output_lines;
        logic [3:0]  phase_now;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        stamp_t     tick_now;
        stamp_t     phase_start;
        logic       first_door;
        logic       other_door;
        logic       open_second_pending;
        logic [2:0] fire_step;
        logic [1:0] prev_requests;
        logic       saw_people;
        stamp_t     open_time;
        stamp_t     empty_time;
        stamp_t     open_due;
        stamp_t     enter_end;
        stamp_t     pass_end;
        logic       open_ok;
        logic       empty_ok;
        logic       due_ok;
        logic       enter_ok;
        logic       pass_ok;
        logic [8:0] lines;
    } state_t;

endpackage

// ===== hdl/tdas_cfg.sv =====
// APB register file for the airlock sequencer timing and option registers.
// Depends on tdas_pkg.
module tdas_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdas_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tdas_pkg::cfg_t                cfg
);

    tdas_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[tdas_pkg::ADDR_BITS-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_confirm_timeout <= 16'd5000;
            cfg_reg.person_wait_timeout  <= 16'd15000;
            cfg_reg.switch_delay         <= 16'd1500;
            cfg_reg.second_close_delay   <= 16'd100;
            cfg_reg.second_max_hold      <= 16'd5000;
            cfg_reg.option_flags         <= 7'd16;
        end else if (wr_en) begin
            case (reg_index)
                tdas_pkg::REG_OPEN_CONFIRM: cfg_reg.open_confirm_timeout <= pwdata[15:0];
                tdas_pkg::REG_PERSON_WAIT:  cfg_reg.person_wait_timeout  <= pwdata[15:0];
                tdas_pkg::REG_SWITCH_DELAY: cfg_reg.switch_delay         <= pwdata[15:0];
                tdas_pkg::REG_CLOSE_DELAY:  cfg_reg.second_close_delay   <= pwdata[15:0];
                tdas_pkg::REG_MAX_HOLD:     cfg_reg.second_max_hold      <= pwdata[15:0];
                tdas_pkg::REG_OPTIONS:      cfg_reg.option_flags         <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            tdas_pkg::REG_OPEN_CONFIRM: prdata = {16'd0, cfg_reg.open_confirm_timeout};
            tdas_pkg::REG_PERSON_WAIT:  prdata = {16'd0, cfg_reg.person_wait_timeout};
            tdas_pkg::REG_SWITCH_DELAY: prdata = {16'd0, cfg_reg.switch_delay};
            tdas_pkg::REG_CLOSE_DELAY:  prdata = {16'd0, cfg_reg.second_close_delay};
            tdas_pkg::REG_MAX_HOLD:     prdata = {16'd0, cfg_reg.second_max_hold};
            tdas_pkg::REG_OPTIONS:      prdata = {25'd0, cfg_reg.option_flags};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/tdas_core.sv =====
// Airlock sequence state and per-tick update: timers, phase logic, door commands.
// Depends on tdas_pkg; driven one tick at a time by the top level.
module tdas_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  tdas_pkg::in_item_t  item,
    input  tdas_pkg::cfg_t      cfg,
    output tdas_pkg::out_item_t result
);

    localparam int TB = tdas_pkg::TIME_BITS;

    tdas_pkg::state_t state_reg;
    tdas_pkg::state_t state_mid;
    tdas_pkg::state_t state_next;

    tdas_pkg::stamp_t now;
    logic             act;
    logic             fire;
    logic             req_a;
    logic             req_b;
    logic             ppos;
    logic             pzero;
    logic             skip;
    logic             wait_empty;
    logic             max_hold;
    logic             cmd_valid;
    logic             cmd_door;
    logic [1:0]       cmd_code;

    function automatic tdas_pkg::stamp_t since(input tdas_pkg::stamp_t a,
                                               input tdas_pkg::stamp_t b);
        return a - b;
    endfunction

    function automatic logic reached(input tdas_pkg::stamp_t a, input tdas_pkg::stamp_t b);
        tdas_pkg::stamp_t d;
        d = a - b;
        return !d[TB-1];
    endfunction

    function automatic logic [8:0] door_lamps(input logic [8:0] ln, input logic door,
                                              input logic open);
        logic [8:0] v;
        v = ln;
        if (door == tdas_pkg::DOOR_B) begin
            v[tdas_pkg::LN_RED_B]   = !open;
            v[tdas_pkg::LN_GREEN_B] = open;
            v[tdas_pkg::LN_STAT_B]  = open;
        end else begin
            v[tdas_pkg::LN_RED_A]   = !open;
            v[tdas_pkg::LN_GREEN_A] = open;
            v[tdas_pkg::LN_STAT_A]  = open;
        end
        return v;
    endfunction

    function automatic logic [8:0] clear_sounds(input logic [8:0] ln);
        logic [8:0] v;
        v = ln;
        v[tdas_pkg::LN_ENTER] = 1'b0;
        v[tdas_pkg::LN_PASS]  = 1'b0;
        v[tdas_pkg::LN_LEAVE] = 1'b0;
        return v;
    endfunction

    function automatic logic [8:0] all_closed(input logic [8:0] ln);
        return clear_sounds(door_lamps(door_lamps(ln, tdas_pkg::DOOR_A, 1'b0),
                                       tdas_pkg::DOOR_B, 1'b0));
    endfunction

    function automatic tdas_pkg::state_t reset_state();
        tdas_pkg::state_t s;
        s            = '0;
        s.phase      = tdas_pkg::PH_IDLE;
        s.other_door = tdas_pkg::DOOR_B;
        return s;
    endfunction

    assign now        = state_reg.tick_now + TB'(1);
    assign act        = cfg.option_flags[tdas_pkg::OPT_AUTO] && !cfg.option_flags[tdas_pkg::OPT_TEST];
    assign fire       = item.fire_raw ^ cfg.option_flags[tdas_pkg::OPT_FIRE_INVERT];
    assign req_a      = item.request_a && act;
    assign req_b      = item.request_b && act;
    assign ppos       = item.people_valid && (item.people_count != 8'd0) && !item.people_count[7];
    assign pzero      = item.people_valid && (item.people_count == 8'd0);
    assign skip       = cfg.option_flags[tdas_pkg::OPT_SKIP_CONFIRM];
    assign wait_empty = cfg.option_flags[tdas_pkg::OPT_WAIT_EMPTY];
    assign max_hold   = cfg.option_flags[tdas_pkg::OPT_MAX_HOLD];

    always_comb begin : pre_bus
        tdas_pkg::state_t s;
        logic             rise_a;
        logic             rise_b;
        logic [15:0]      st_first;
        logic [15:0]      st_other;
        s      = state_reg;
        rise_a = req_a && !state_reg.prev_requests[0];
        rise_b = req_b && !state_reg.prev_requests[1];
        s.tick_now      = now;
        s.prev_requests = {req_b, req_a};

        if (s.enter_ok && reached(now, s.enter_end)) begin
            s.lines[tdas_pkg::LN_ENTER] = 1'b0;
            s.enter_ok = 1'b0;
        end
        if (s.pass_ok && reached(now, s.pass_end)) begin
            s.lines[tdas_pkg::LN_PASS] = 1'b0;
            s.pass_ok = 1'b0;
        end

        if (!act && !fire) begin
            s.phase               = tdas_pkg::PH_IDLE;
            s.open_second_pending = 1'b0;
            s.fire_step           = 3'd0;
            s.due_ok              = 1'b0;
            s.open_ok             = 1'b0;
            s.empty_ok            = 1'b0;
            s.saw_people          = 1'b0;
        end
        if (fire) begin
            if (s.phase != tdas_pkg::PH_FIRE_SEND && s.phase != tdas_pkg::PH_FIRE_HOLD) begin
                s.phase       = tdas_pkg::PH_FIRE_SEND;
                s.fire_step   = 3'd0;
                s.phase_start = now;
            end
        end else if (s.phase == tdas_pkg::PH_FIRE_HOLD) begin
            s.phase       = tdas_pkg::PH_FIRE_EXIT;
            s.fire_step   = 3'd0;
            s.phase_start = now;
        end

        st_first = s.first_door ? item.door_b_status : item.door_a_status;
        st_other = s.other_door ? item.door_b_status : item.door_a_status;

        case (s.phase)
            tdas_pkg::PH_IDLE: begin
                if (act) s.lines = all_closed(s.lines);
                if (act && !fire && !(req_a && req_b) && !(rise_a && rise_b)) begin
                    if ((rise_a && !req_b) || (rise_b && !req_a)) begin
                        s.first_door  = !rise_a;
                        s.other_door  = rise_a;
                        s.phase       = tdas_pkg::PH_OPEN1_SEND;
                        s.phase_start = now;
                    end
                end
            end
            tdas_pkg::PH_OPEN1_WAIT: begin
                if (skip || ((st_first & tdas_pkg::MASK_FIRST_OPEN) != 16'd0)) begin
                    s.phase       = tdas_pkg::PH_WAIT_PERSON;
                    s.phase_start = now;
                end else if (since(now, s.phase_start) >= TB'(cfg.open_confirm_timeout)) begin
                    s.open_second_pending = 1'b0;
                    s.phase               = tdas_pkg::PH_CLOSE1_SEND;
                end
            end
            tdas_pkg::PH_WAIT_PERSON: begin
                if (ppos) begin
                    s.other_door             = !s.first_door;
                    s.lines[tdas_pkg::LN_PASS] = 1'b1;
                    s.pass_end               = now + TB'(tdas_pkg::PULSE_MS);
                    s.pass_ok                = 1'b1;
                    s.open_second_pending    = 1'b1;
                    s.open_due               = now + TB'(cfg.switch_delay);
                    s.due_ok                 = 1'b1;
                    s.phase                  = tdas_pkg::PH_CLOSE1_SEND;
                    s.phase_start            = now;
                end
                if (s.phase == tdas_pkg::PH_WAIT_PERSON &&
                    since(now, s.phase_start) >= TB'(cfg.person_wait_timeout)) begin
                    s.open_second_pending = 1'b0;
                    s.phase               = tdas_pkg::PH_CLOSE1_SEND;
                end
            end
            tdas_pkg::PH_OPEN2_WAIT: begin
                if (skip || ((st_other & tdas_pkg::MASK_SECOND_OPEN) != 16'd0) ||
                    since(now, s.phase_start) >= TB'(cfg.open_confirm_timeout)) begin
                    s.phase       = tdas_pkg::PH_HOLD2;
                    s.phase_start = now;
                    s.open_time   = now;
                    s.open_ok     = 1'b1;
                    s.empty_ok    = 1'b0;
                    s.saw_people  = 1'b0;
                end
            end
            tdas_pkg::PH_HOLD2: begin
                if (ppos) begin
                    s.saw_people = 1'b1;
                    s.empty_ok   = 1'b0;
                end else if (pzero) begin
                    if (!wait_empty) begin
                        if (s.open_ok &&
                            since(now, s.open_time) >= TB'(cfg.second_close_delay))
                            s.phase = tdas_pkg::PH_CLOSE2_SEND;
                    end else if (s.saw_people) begin
                        if (!s.empty_ok) begin
                            s.empty_time = now;
                            s.empty_ok   = 1'b1;
                        end
                        if (since(now, s.empty_time) >= TB'(cfg.second_close_delay))
                            s.phase = tdas_pkg::PH_CLOSE2_SEND;
                    end
                end
                if (s.phase == tdas_pkg::PH_HOLD2 && max_hold && s.open_ok &&
                    since(now, s.open_time) >= TB'(cfg.second_max_hold))
                    s.phase = tdas_pkg::PH_CLOSE2_SEND;
            end
            default: ;
        endcase
        state_mid = s;
    end

    always_comb begin : bus_stage
        tdas_pkg::state_t s;
        s         = state_mid;
        cmd_valid = 1'b0;
        cmd_door  = tdas_pkg::DOOR_A;
        cmd_code  = tdas_pkg::CMD_OPEN_FIRST;
        if (item.bus_ready) begin
            if (s.phase == tdas_pkg::PH_SWITCH_DELAY && s.due_ok && reached(now, s.open_due)) begin
                s.due_ok = 1'b0;
                s.phase  = tdas_pkg::PH_OPEN2_SEND;
            end
            case (s.phase)
                tdas_pkg::PH_FIRE_SEND: begin
                    if (s.fire_step < 3'd4) begin
                        cmd_valid = 1'b1;
                        cmd_door  = s.fire_step[1];
                        cmd_code  = s.fire_step[0] ? tdas_pkg::CMD_OPEN_SECOND
                                                   : tdas_pkg::CMD_OPEN_FIRST;
                        s.lines   = clear_sounds(door_lamps(door_lamps(s.lines,
                                        tdas_pkg::DOOR_A, 1'b1), tdas_pkg::DOOR_B, 1'b1));
                        s.fire_step = s.fire_step + 3'd1;
                        if (s.fire_step >= 3'd4) s.phase = tdas_pkg::PH_FIRE_HOLD;
                    end
                end
                tdas_pkg::PH_FIRE_EXIT: begin
                    if (s.fire_step < 3'd2) begin
                        cmd_valid   = 1'b1;
                        cmd_door    = s.fire_step[0];
                        cmd_code    = tdas_pkg::CMD_CLOSE;
                        s.fire_step = s.fire_step + 3'd1;
                        if (s.fire_step >= 3'd2) s.phase = tdas_pkg::PH_IDLE;
                        s.lines = all_closed(s.lines);
                    end
                end
                tdas_pkg::PH_OPEN1_SEND: begin
                    cmd_valid     = 1'b1;
                    cmd_door      = s.first_door;
                    cmd_code      = tdas_pkg::CMD_OPEN_FIRST;
                    s.phase       = tdas_pkg::PH_OPEN1_WAIT;
                    s.phase_start = now;
                    if (act) begin
                        s.lines[tdas_pkg::LN_LEAVE] = 1'b0;
                        s.lines[tdas_pkg::LN_PASS]  = 1'b0;
                        s.lines[tdas_pkg::LN_ENTER] = 1'b1;
                        s.enter_end = now + TB'(tdas_pkg::PULSE_MS);
                        s.enter_ok  = 1'b1;
                        s.lines = door_lamps(door_lamps(s.lines, s.first_door, 1'b1),
                                             !s.first_door, 1'b0);
                    end
                end
                tdas_pkg::PH_CLOSE1_SEND: begin
                    cmd_valid = 1'b1;
                    cmd_door  = s.first_door;
                    cmd_code  = tdas_pkg::CMD_CLOSE;
                    if (act) s.lines = door_lamps(s.lines, s.first_door, 1'b0);
                    s.phase = s.open_second_pending ? tdas_pkg::PH_SWITCH_DELAY
                                                    : tdas_pkg::PH_IDLE;
                    s.open_second_pending = 1'b0;
                    s.phase_start         = now;
                end
                tdas_pkg::PH_OPEN2_SEND: begin
                    cmd_valid     = 1'b1;
                    cmd_door      = s.other_door;
                    cmd_code      = tdas_pkg::CMD_OPEN_SECOND;
                    s.saw_people  = 1'b0;
                    s.open_ok     = 1'b0;
                    s.empty_ok    = 1'b0;
                    s.phase       = tdas_pkg::PH_OPEN2_WAIT;
                    s.phase_start = now;
                    if (act) begin
                        s.lines[tdas_pkg::LN_ENTER] = 1'b0;
                        s.lines = door_lamps(s.lines, s.other_door, 1'b1);
                    end
                end
                tdas_pkg::PH_CLOSE2_SEND: begin
                    cmd_valid = 1'b1;
                    cmd_door  = s.other_door;
                    cmd_code  = tdas_pkg::CMD_CLOSE;
                    if (act) begin
                        s.lines[tdas_pkg::LN_PASS]  = 1'b0;
                        s.lines[tdas_pkg::LN_ENTER] = 1'b0;
                        s.lines = door_lamps(s.lines, s.other_door, 1'b0);
                    end
                    s.phase       = tdas_pkg::PH_IDLE;
                    s.phase_start = now;
                end
                default: ;
            endcase
        end
        state_next = s;
    end

    assign result.command_valid = cmd_valid;
    assign result.command_door  = cmd_door;
    assign result.command_code  = cmd_code;
    assign result.output_lines  = state_next.lines;
    assign result.phase_now     = state_next.phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_state();
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/two_door_airlock_sequencer.sv =====
// Top level of the two-door airlock sequencer: stream ports, input and result
// registers. Depends on tdas_pkg, tdas_cfg and tdas_core.
//
// One transaction on the s_ side is one millisecond tick; each tick yields exactly
// one transaction on the m_ side with an optional door command, the latched lamp
// and sound lines and the phase after the tick. A tick is taken every clock cycle
// while m_ is not stalled; it is held in the input register, then the phase update
// writes the result register, which drives m_. Back pressure on m_ stalls the input
// once both registers are full. The user writes the registers over APB only while
// no tick is in flight; the block itself does not enforce this.
module two_door_airlock_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, low bit up: request_a, request_b, fire_raw, door_a_status[16],
    // door_b_status[16], people_valid, people_count[8], bus_ready, zero fill
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,
    // m_tdata, low bit up: command_valid, command_door, command_code[2],
    // output_lines[9], phase_now[4], zero fill
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tdas_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tdas_pkg::cfg_t      cfg;
    tdas_pkg::in_item_t  in_item_reg;
    tdas_pkg::out_item_t result;
    tdas_pkg::out_item_t out_item_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                step_en;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_item_reg.phase_now, out_item_reg.output_lines,
                       out_item_reg.command_code, out_item_reg.command_door,
                       out_item_reg.command_valid};

    tdas_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdas_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.request_a     <= s_tdata[0];
            in_item_reg.request_b     <= s_tdata[1];
            in_item_reg.fire_raw      <= s_tdata[2];
            in_item_reg.door_a_status <= s_tdata[18:3];
            in_item_reg.door_b_status <= s_tdata[34:19];
            in_item_reg.people_valid  <= s_tdata[35];
            in_item_reg.people_count  <= s_tdata[43:36];
            in_item_reg.bus_ready     <= s_tdata[44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) out_item_reg <= result;
    end

endmodule
